/* design/sobolsg_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the Sobol sequence generator.
// No dependencies; used by the core and its port checker.
package sobolsg_pkg;

  // Default sizes of the generator
  localparam int DIMS_DEF       = 16;
  localparam int COLS_DEF       = 32;
  localparam int MAX_DEGREE_DEF = 13;
  localparam int FRAC_BITS_DEF  = 52;

  // Fixed port widths
  localparam int LOAD_W    = 52;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIR_W     = 32;

  typedef enum logic [2:0] {
    OP_LOAD_POLY  = 3'd0,
    OP_LOAD_INIT  = 3'd1,
    OP_LOAD_SHIFT = 3'd2,
    OP_START      = 3'd3,
    OP_NEXT       = 3'd4
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMS_IN_USE  = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_SKIP_COUNT   = 2'd2,
    CFG_SHIFT_ENABLE = 2'd3
  } cfg_reg_t;

endpackage

/* design/sobolsg_ram.sv */
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sobolsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/sobol_sequence_generator_core.sv */
`timescale 1ns / 1ps
// Top level of the Sobol sequence generator: sequencer, point state and stores.
// Depends on sobolsg_pkg and sobolsg_ram.
//
// Channel   | Handshake              | Payload
// ----------+------------------------+------------------------------------------
// command   | start & !busy          | opcode, dim_select, entry_select,
//           |                        | load_value
// result    | result_strobe (1 cyc)  | out_dim, coordinate, last_of_point,
//           |                        | exhausted
// config    | cfg_we                 | cfg_index, cfg_data
//
// Loads take effect in the accept cycle and leave busy low.
// Next: S_NUPD folds one direction column into every coordinate, a dimension
// at a time (one read of the direction RAM per cycle), then S_EMIT emits the
// coordinates, or S_EXH the exhausted result. Start: per dimension S_BDIM,
// then per column S_BCOL alone (degree-0 polynomial), with S_BINIT (initial
// number) or with S_BACC (recurrence, one read per term), then S_EMIT or S_EXH.
// Reset is synchronous and clears stores that have a defined reset value;
// the direction RAM is not cleared. Results cannot be stalled by the receiver.
module sobol_sequence_generator_core #(
  parameter int DIMS       = sobolsg_pkg::DIMS_DEF,
  parameter int COLS       = sobolsg_pkg::COLS_DEF,
  parameter int MAX_DEGREE = sobolsg_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = sobolsg_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          opcode,
  input  logic [3:0]                          dim_select,
  input  logic [3:0]                          entry_select,
  input  logic [sobolsg_pkg::LOAD_W-1:0]      load_value,
  output logic                                result_strobe,
  output logic [3:0]                          out_dim,
  output logic [FRAC_BITS-1:0]                coordinate,
  output logic                                last_of_point,
  output logic                                exhausted,
  input  logic                                cfg_we,
  input  logic [sobolsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sobolsg_pkg::CFG_W-1:0]       cfg_data
);

  localparam int DW    = DIMS > 1 ? $clog2(DIMS) : 1;
  localparam int NDW   = $clog2(DIMS + 1) > 0 ? $clog2(DIMS + 1) : 1;
  localparam int CW    = COLS > 1 ? $clog2(COLS) : 1;
  localparam int DGW   = $clog2(MAX_DEGREE + 1) > 0 ? $clog2(MAX_DEGREE + 1) : 1;
  localparam int PW    = MAX_DEGREE + 1;
  localparam int DIR_D = DIMS * (1 << CW);
  localparam int DAW   = DIR_D > 1 ? $clog2(DIR_D) : 1;
  localparam int INI_D = DIMS * MAX_DEGREE;
  localparam int IAW   = INI_D > 1 ? $clog2(INI_D) : 1;
  localparam int DRW   = sobolsg_pkg::DIR_W;

  typedef enum logic [2:0] {
    S_IDLE, S_BDIM, S_BCOL, S_BINIT, S_BACC, S_NUPD, S_EMIT, S_EXH
  } state_t;

  state_t state;

  // Configuration registers
  logic [4:0]     dims_reg;
  logic [5:0]     cols_reg;
  logic [31:0]    skip_reg;
  logic           shift_en;

  // Stores
  logic [PW-1:0]        poly      [DIMS];
  logic [FRAC_BITS-1:0] shift_val [DIMS];
  logic [DRW-1:0]       cp        [DIMS];
  logic [INI_D-1:0]     init_valid;

  // Sequencer registers
  logic [32:0]    counter;
  logic           exh_q;
  logic [31:0]    gray_q;
  logic [DW-1:0]  d_q;
  logic [DW-1:0]  e_q;
  logic [CW-1:0]  j_q;
  logic [CW-1:0]  col_q;
  logic [DGW-1:0] k_q;
  logic [DGW-1:0] deg_q;
  logic [PW-1:0]  poly_q;
  logic [DRW-1:0] acc_q;
  logic [DRW-1:0] pt_acc;
  logic           init_vld_q;
  logic [5:0]     nc_b;

  // Memory ports
  logic           dir_we;
  logic [DAW-1:0] dir_waddr;
  logic [DRW-1:0] dir_wdata;
  logic           dir_re;
  logic [DAW-1:0] dir_raddr;
  logic [DRW-1:0] dir_rdata;
  logic           ini_we;
  logic [IAW-1:0] ini_waddr;
  logic           ini_re;
  logic [IAW-1:0] ini_raddr;
  logic [DRW-1:0] ini_rdata;

  // Derived values
  logic [5:0]           nc;
  logic [NDW-1:0]       nd;
  logic [32:0]          top;
  logic                 accept;
  logic                 start_exh;
  logic                 next_exh;
  logic [31:0]          low_c;
  logic [31:0]          low_zero;
  logic [4:0]           col5;
  logic [CW-1:0]        col_now;
  logic [DGW-1:0]       deg_sel;
  logic [6:0]           jk_base;
  logic                 j_below_deg;
  logic [DRW-1:0]       acc_next;
  logic [DRW-1:0]       m_new;
  logic [DRW-1:0]       m_scaled;
  logic [DRW-1:0]       pt_next;
  logic                 col_done;
  logic                 last_col;
  logic                 last_dim;
  logic [5:0]           nupd_sh;
  logic                 col_live;
  logic [6:0]           frac_sh;
  logic [FRAC_BITS-1:0] coord_sel;
  logic                 last_emit;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Clamp the register values to the supported ranges
  always_comb begin
    if (cols_reg == 6'd0) begin
      nc = 6'd1;
    end else if (int'(cols_reg) > COLS) begin
      nc = 6'(COLS);
    end else begin
      nc = cols_reg;
    end
    if (dims_reg == 5'd0) begin
      nd = NDW'(1);
    end else if (int'(dims_reg) > DIMS) begin
      nd = NDW'(DIMS);
    end else begin
      nd = NDW'(dims_reg);
    end
  end

  assign top       = (33'd1 << nc) - 33'd1;
  assign start_exh = {1'b0, skip_reg} > top;
  assign next_exh  = counter >= top;

  // Column of the counter's lowest zero bit: isolate it, then encode
  assign low_c    = counter[31:0];
  assign low_zero = ~low_c & (low_c + 32'd1);
  always_comb begin
    col5 = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (low_zero[i]) begin
        col5 = col5 | 5'(i);
      end
    end
  end
  assign col_now = CW'(col5);

  // Degree of the polynomial of the dimension being built
  always_comb begin
    deg_sel = '0;
    for (int k = 1; k <= MAX_DEGREE; k++) begin
      if (poly[d_q][k]) begin
        deg_sel = DGW'(k);
      end
    end
  end

  assign jk_base     = 7'(j_q) - 7'(deg_q);
  assign j_below_deg = int'(j_q) < int'(deg_q);

  // One recurrence term per cycle: the plain m[j-deg] term on the first step,
  // plus the shifted term where the polynomial bit is set
  always_comb begin
    acc_next = acc_q;
    if (k_q == '0) begin
      acc_next = acc_next ^ dir_rdata;
    end
    if (poly_q[k_q]) begin
      acc_next = acc_next ^ (dir_rdata << (deg_q - k_q));
    end
  end

  // Value of the column finished this cycle, if any
  always_comb begin
    col_done = 1'b0;
    m_new    = '0;
    unique case (state)
      S_BCOL: begin
        if (deg_q == '0) begin
          col_done = 1'b1;
          m_new    = DRW'(1);
        end
      end
      S_BINIT: begin
        col_done = 1'b1;
        m_new    = init_vld_q ? ini_rdata : '0;
      end
      S_BACC: begin
        if (k_q == deg_q - DGW'(1)) begin
          col_done = 1'b1;
          m_new    = acc_next;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_scaled = m_new << (nc - 6'd1 - 6'(j_q));
  assign pt_next  = pt_acc ^ (gray_q[5'(j_q)] ? m_scaled : '0);
  assign last_col = (j_q == CW'(nc - 6'd1));
  assign last_dim = (d_q == DW'(DIMS - 1));

  assign dir_we    = col_done;
  assign dir_waddr = DAW'({d_q, j_q});
  assign dir_wdata = m_new;

  // Direction RAM read: one column per cycle, issued a cycle ahead of use
  always_comb begin
    dir_re    = 1'b0;
    dir_raddr = DAW'({d_q, j_q});
    unique case (state)
      S_IDLE: begin
        if (accept && opcode == sobolsg_pkg::OP_NEXT) begin
          dir_re    = 1'b1;
          dir_raddr = DAW'({DW'(0), col_now});
        end
      end
      S_BCOL: begin
        if (deg_q != '0 && !j_below_deg) begin
          dir_re    = 1'b1;
          dir_raddr = DAW'({d_q, CW'(jk_base)});
        end
      end
      S_BACC: begin
        if (k_q != deg_q - DGW'(1)) begin
          dir_re    = 1'b1;
          dir_raddr = DAW'({d_q, CW'(jk_base + 7'(k_q) + 7'd1)});
        end
      end
      S_NUPD: begin
        if (!last_dim) begin
          dir_re    = 1'b1;
          dir_raddr = DAW'({d_q + DW'(1), col_q});
        end
      end
      default: begin
      end
    endcase
  end

  assign ini_we    = accept && opcode == sobolsg_pkg::OP_LOAD_INIT &&
                     int'(dim_select) < DIMS && int'(entry_select) < MAX_DEGREE;
  assign ini_waddr = IAW'(int'(dim_select) * MAX_DEGREE + int'(entry_select));
  assign ini_re    = (state == S_BCOL) && deg_q != '0 && j_below_deg;
  assign ini_raddr = IAW'(int'(d_q) * MAX_DEGREE + int'(j_q));

  // The table holds raw direction numbers; scale them by the column count of
  // the last build, and treat columns past that build as zero
  assign nupd_sh   = nc_b - 6'd1 - 6'(col_q);
  assign col_live  = 6'(col_q) < nc_b;
  assign frac_sh   = 7'(FRAC_BITS) - 7'(nc);
  assign coord_sel = (FRAC_BITS'(cp[e_q]) << frac_sh) ^
                     (shift_en ? shift_val[e_q] : '0);
  assign last_emit = (NDW'(e_q) + NDW'(1)) == nd;

  sobolsg_ram #(
    .WIDTH (DRW),
    .DEPTH (DIR_D)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  sobolsg_ram #(
    .WIDTH (DRW),
    .DEPTH (INI_D)
  ) u_init_ram (
    .clk   (clk),
    .we    (ini_we),
    .waddr (ini_waddr),
    .wdata (DRW'(load_value)),
    .re    (ini_re),
    .raddr (ini_raddr),
    .rdata (ini_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_reg <= 5'd1;
      cols_reg <= 6'd32;
      skip_reg <= '0;
      shift_en <= 1'b0;
    end else if (cfg_we) begin
      unique case (sobolsg_pkg::cfg_reg_t'(cfg_index))
        sobolsg_pkg::CFG_DIMS_IN_USE:  dims_reg <= cfg_data[4:0];
        sobolsg_pkg::CFG_COLUMN_COUNT: cols_reg <= cfg_data[5:0];
        sobolsg_pkg::CFG_SKIP_COUNT:   skip_reg <= cfg_data;
        sobolsg_pkg::CFG_SHIFT_ENABLE: shift_en <= cfg_data[0];
      endcase
    end
  end

  // Sequencer, stores and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
      counter       <= '0;
      init_valid    <= '0;
      for (int i = 0; i < DIMS; i++) begin
        poly[i]      <= '0;
        shift_val[i] <= '0;
        cp[i]        <= '0;
      end
    end else begin
      result_strobe <= 1'b0;
      if (ini_re) begin
        init_vld_q <= init_valid[ini_raddr];
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority case (opcode)
              sobolsg_pkg::OP_LOAD_POLY: begin
                if (int'(dim_select) < DIMS) begin
                  poly[DW'(dim_select)] <= PW'(load_value);
                end
              end
              sobolsg_pkg::OP_LOAD_INIT: begin
                if (ini_we) begin
                  init_valid[ini_waddr] <= 1'b1;
                end
              end
              sobolsg_pkg::OP_LOAD_SHIFT: begin
                if (int'(dim_select) < DIMS) begin
                  shift_val[DW'(dim_select)] <= FRAC_BITS'(load_value);
                end
              end
              sobolsg_pkg::OP_START: begin
                // Build the table even when the skip is out of range
                exh_q  <= start_exh;
                gray_q <= skip_reg ^ (skip_reg >> 1);
                nc_b   <= nc;
                if (!start_exh) begin
                  counter <= {1'b0, skip_reg};
                end
                d_q   <= '0;
                state <= S_BDIM;
              end
              sobolsg_pkg::OP_NEXT: begin
                if (next_exh) begin
                  state <= S_EXH;
                end else begin
                  col_q <= col_now;
                  d_q   <= '0;
                  state <= S_NUPD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_BDIM: begin
          deg_q  <= deg_sel;
          poly_q <= poly[d_q];
          j_q    <= '0;
          pt_acc <= '0;
          state  <= S_BCOL;
        end
        S_BCOL: begin
          if (deg_q != '0) begin
            acc_q <= '0;
            k_q   <= '0;
            state <= j_below_deg ? S_BINIT : S_BACC;
          end
        end
        S_BINIT: begin
        end
        S_BACC: begin
          acc_q <= acc_next;
          k_q   <= k_q + DGW'(1);
        end
        S_NUPD: begin
          cp[d_q] <= cp[d_q] ^ (col_live ? (dir_rdata << nupd_sh) : '0);
          if (last_dim) begin
            counter <= counter + 33'd1;
            e_q     <= '0;
            state   <= S_EMIT;
          end else begin
            d_q <= d_q + DW'(1);
          end
        end
        S_EMIT: begin
          result_strobe <= 1'b1;
          out_dim       <= 4'(e_q);
          coordinate    <= coord_sel;
          last_of_point <= last_emit;
          exhausted     <= 1'b0;
          if (last_emit) begin
            state <= S_IDLE;
          end else begin
            e_q <= e_q + DW'(1);
          end
        end
        S_EXH: begin
          result_strobe <= 1'b1;
          out_dim       <= '0;
          coordinate    <= '0;
          last_of_point <= 1'b0;
          exhausted     <= 1'b1;
          state         <= S_IDLE;
        end
      endcase

      // Close a column: store it, fold it into the point, advance
      if (col_done) begin
        pt_acc <= pt_next;
        if (last_col) begin
          if (!exh_q) begin
            cp[d_q] <= pt_next;
          end
          if (last_dim) begin
            e_q   <= '0;
            state <= exh_q ? S_EXH : S_EMIT;
          end else begin
            d_q   <= d_q + DW'(1);
            state <= S_BDIM;
          end
        end else begin
          j_q   <= j_q + CW'(1);
          state <= S_BCOL;
        end
      end
    end
  end

endmodule

/* design/sobolsg_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the Sobol sequence generator, bound to the top level.
// Depends on sobolsg_pkg.
module sobolsg_checker #(
  parameter int FRAC_BITS = sobolsg_pkg::FRAC_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [2:0]           opcode,
  input logic                 result_strobe,
  input logic [3:0]           out_dim,
  input logic [FRAC_BITS-1:0] coordinate,
  input logic                 last_of_point,
  input logic                 exhausted
);

  a_exh_payload: assert property (@(posedge clk) disable iff (rst)
    result_strobe && exhausted |-> out_dim == 4'd0 && coordinate == '0 && !last_of_point)
    else $error("exhausted result carries a payload");

  a_point_end: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (last_of_point || exhausted) |=> !result_strobe)
    else $error("result follows the end of a transaction");

  a_dim_step: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_of_point && !exhausted |=>
      result_strobe && out_dim == $past(out_dim) + 4'd1)
    else $error("coordinates of a point are not consecutive");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (opcode == sobolsg_pkg::OP_LOAD_POLY ||
      opcode == sobolsg_pkg::OP_LOAD_INIT || opcode == sobolsg_pkg::OP_LOAD_SHIFT)
      |=> !busy)
    else $error("load left the block busy");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !result_strobe)
    else $error("result without a transaction in progress");

endmodule

bind sobol_sequence_generator_core sobolsg_checker #(.FRAC_BITS(FRAC_BITS)) u_sobolsg_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .opcode        (opcode),
  .result_strobe (result_strobe),
  .out_dim       (out_dim),
  .coordinate    (coordinate),
  .last_of_point (last_of_point),
  .exhausted     (exhausted)
);
